@@ sv/bqx_pkg.sv @@
// Package for the bracketed quote to XML converter.
// Holds the item types, the expansion kind codes and the expansion text tables.
// No dependencies.
package bqx_pkg;

  // One input item: a source byte and the end-of-buffer marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // One result item: an XML byte and the end-of-expansion marker.
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_end;
  } out_t;

  // Character constants used by the classifier and the text tables.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChNl     = 8'h0A;

  // Longest expansion is six bytes, so a byte index needs three bits.
  localparam int unsigned MaxLen = 6;
  localparam int unsigned IdxW   = $clog2(MaxLen + 1);

  // What one input byte expands into.
  typedef enum logic [3:0] {
    K_NONE   = 4'd0,
    K_OPEN   = 4'd1,
    K_CLOSE  = 4'd2,
    K_NOPEN  = 4'd3,
    K_NCLOSE = 4'd4,
    K_AMP    = 4'd5,
    K_LT     = 4'd6,
    K_GT     = 4'd7,
    K_BYTE   = 4'd8
  } kind_e;

  // Classifier result handed from the decoder to the top level.
  typedef struct packed {
    kind_e kind;
    logic  flag_next;
  } dec_t;

  // Number of bytes an expansion produces.
  function automatic logic [IdxW-1:0] text_len(input kind_e kind);
    logic [IdxW-1:0] len;
    case (kind)
      K_OPEN:   len = IdxW'(6);
      K_CLOSE:  len = IdxW'(4);
      K_NOPEN:  len = IdxW'(4);
      K_NCLOSE: len = IdxW'(5);
      K_AMP:    len = IdxW'(5);
      K_LT:     len = IdxW'(4);
      K_GT:     len = IdxW'(4);
      K_BYTE:   len = IdxW'(1);
      default:  len = IdxW'(0);
    endcase
    return len;
  endfunction

  // Byte at position idx of an expansion; a plain byte passes through.
  function automatic logic [7:0] text_char(input kind_e kind, input logic [IdxW-1:0] idx,
                                           input logic [7:0] src);
    logic [47:0] txt;
    logic [7:0]  ch;
    case (kind)
      K_OPEN:   txt = {"<p v=", ChQuote};
      K_CLOSE:  txt = {ChQuote, "/>", ChNl, 16'h0};
      K_NOPEN:  txt = {"<n>", ChNl, 16'h0};
      K_NCLOSE: txt = {"</n>", ChNl, 8'h0};
      K_AMP:    txt = {"&amp;", 8'h0};
      K_LT:     txt = {"&lt;", 16'h0};
      K_GT:     txt = {"&gt;", 16'h0};
      default:  txt = {src, 40'h0};
    endcase
    case (idx)
      IdxW'(0): ch = txt[47:40];
      IdxW'(1): ch = txt[39:32];
      IdxW'(2): ch = txt[31:24];
      IdxW'(3): ch = txt[23:16];
      IdxW'(4): ch = txt[15:8];
      IdxW'(5): ch = txt[7:0];
      default:  ch = 8'h0;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/bqx_decode.sv @@
// Byte classifier for the bracketed quote to XML converter.
// Decides the expansion of one byte and the next in-quote flag.
// Depends on bqx_pkg.
module bqx_decode import bqx_pkg::*; (
  input  logic [7:0] byte_i,
  input  logic       inside_i,
  output dec_t       dec_o
);

  // Quotes toggle the flag; braces act only outside quotes; escapes only inside.
  always_comb begin
    dec_o.kind      = K_NONE;
    dec_o.flag_next = inside_i;
    if (byte_i == ChQuote) begin
      dec_o.kind      = inside_i ? K_CLOSE : K_OPEN;
      dec_o.flag_next = !inside_i;
    end else if (byte_i == ChLBrace) begin
      if (!inside_i) dec_o.kind = K_NOPEN;
    end else if (byte_i == ChRBrace) begin
      if (!inside_i) dec_o.kind = K_NCLOSE;
    end else if (inside_i) begin
      if (byte_i == ChAmp) begin
        dec_o.kind = K_AMP;
      end else if (byte_i == ChLt) begin
        dec_o.kind = K_LT;
      end else if (byte_i == ChGt) begin
        dec_o.kind = K_GT;
      end else begin
        dec_o.kind = K_BYTE;
      end
    end
  end

endmodule

@@ sv/bracketed_quote_to_xml.sv @@
// Top level of the bracketed quote to XML converter.
// Holds the expansion register, the byte sequencer and the output register.
// Depends on bqx_pkg and bqx_decode.

// Each input item is classified on acceptance and expands into zero to six
// XML bytes, which leave one per cycle through a registered output while the
// output is not stalled. An item holds the block, as there is a single output
// byte port, until the last byte of its expansion is emitted; a dropped byte
// holds nothing and the next item may follow at once. The next item is taken
// in the same cycle that the last byte of the current expansion moves to the
// output register, so a stream of pass-through bytes runs at one item per cycle
// while the output is not stalled. out_end marks the last byte of each
// expansion; in_last clears the quote state after its own byte.
module bracketed_quote_to_xml import bqx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic            flag_q;
  logic            job_valid_q;
  kind_e           kind_q;
  logic [7:0]      byte_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] len_q;
  logic            out_valid_q;
  out_t            out_q;

  dec_t            dec;
  logic            out_free;
  logic            emit;
  logic            job_done;
  logic            in_acc;

  bqx_decode u_decode (
    .byte_i   (in_data_i.in_byte),
    .inside_i (flag_q),
    .dec_o    (dec)
  );

  // Handshake: the expansion slot frees as its last byte leaves.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = job_valid_q && out_free;
  assign job_done   = emit && (idx_q == len_q - IdxW'(1));
  assign in_stall_o = job_valid_q && !job_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Quote flag and expansion register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q      <= 1'b0;
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (in_acc) begin
        flag_q <= in_data_i.in_last ? 1'b0 : dec.flag_next;
      end
      if (in_acc && dec.kind != K_NONE) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (job_done) begin
        job_valid_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Expansion payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc && dec.kind != K_NONE) begin
      kind_q <= dec.kind;
      byte_q <= in_data_i.in_byte;
      len_q  <= text_len(dec.kind);
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_char <= text_char(kind_q, idx_q, byte_q);
      out_q.out_end  <= (idx_q == len_q - IdxW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The byte index never runs past the end of the expansion.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (idx_q < len_q))
    else $error("expansion index out of range");

  // A last-marked item leaves the block outside quotes.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.in_last) |=> !flag_q)
    else $error("quote flag not cleared after last item");

  // A byte that is not the end of its expansion carries no end marker.
  a_mid_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !job_done) |=> (out_valid_o && !out_data_o.out_end))
    else $error("end marker on a middle byte");

  // An expansion ends with the end marker on its final byte.
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_done |=> (out_valid_o && out_data_o.out_end))
    else $error("missing end marker");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the bracketed quote to XML converter.
// Drives source bytes, predicts the XML bytes each one expands into and checks them in order.
// Depends on bqx_pkg and bracketed_quote_to_xml.
module tb_top;
  import bqx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Predictor state and the XML bytes still owed by the block.
  bit   quote_open = 1'b0;
  out_t expected_xml[$];
  int   errors = 0;
  int   sent_items = 0;
  bit   quiet = 1'b0;

  bracketed_quote_to_xml DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expand one accepted byte into the XML bytes it should produce and queue them.
  // Returns the number of bytes queued.
  function automatic int predict_xml(in_t it);
    string      txt;
    logic       pass;
    logic [7:0] ch;
    int         n;
    txt  = "";
    pass = 1'b0;
    if (it.in_byte == ChQuote) begin
      txt = quote_open ? "\"/>\n" : "<p v=\"";
      quote_open = !quote_open;
    end else if (it.in_byte == ChLBrace) begin
      if (!quote_open) txt = "<n>\n";
    end else if (it.in_byte == ChRBrace) begin
      if (!quote_open) txt = "</n>\n";
    end else if (quote_open) begin
      if (it.in_byte == ChAmp) txt = "&amp;";
      else if (it.in_byte == ChLt) txt = "&lt;";
      else if (it.in_byte == ChGt) txt = "&gt;";
      else pass = 1'b1;
    end
    n = pass ? 1 : txt.len();
    for (int i = 0; i < n; i++) begin
      ch = pass ? it.in_byte : txt[i];
      expected_xml.push_back('{out_char: ch, out_end: (i == n - 1)});
    end
    // The end-of-buffer marker clears the quote state after the byte's own effect.
    if (it.in_last) quote_open = 1'b0;
    return n;
  endfunction

  // Offer one item, with random idle cycles ahead of it outside a quiet stretch, and wait until it is taken.
  task automatic send_item(input logic [7:0] b, input logic last);
    in_t it;
    it.in_byte = b;
    it.in_last = last;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 27) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    void'(predict_xml(it));
    sent_items++;
    @(negedge clk_i);
  endtask

  // Hold the input side idle until every owed XML byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (expected_xml.size() > 0) @(negedge clk_i);
  endtask

  // Receiver stalls at random, except during a quiet stretch.
  always @(negedge clk_i) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 27);
  end

  // Compare every accepted XML byte with the oldest expectation.
  always @(posedge clk_i) begin
    out_t exp_item;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_xml.size() == 0) begin
        $error("unexpected output byte %h (end %b)", out_data.out_char, out_data.out_end);
        errors++;
      end else begin
        exp_item = expected_xml.pop_front();
        if (out_data.out_char !== exp_item.out_char) begin
          $error("out_char: expected %h, got %h", exp_item.out_char, out_data.out_char);
          errors++;
        end
        if (out_data.out_end !== exp_item.out_end) begin
          $error("out_end: expected %b, got %b", exp_item.out_end, out_data.out_end);
          errors++;
        end
      end
    end
  end

  // Braces outside quotes, and bytes outside quotes that are dropped.
  task automatic test_nodes();
    send_item(ChLBrace, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(ChAmp, 1'b0);
    send_item(ChRBrace, 1'b0);
  endtask

  // Quoted strings: escapes, pass-through extremes, braces inside, doubled quote.
  task automatic test_quotes();
    send_item(ChQuote, 1'b0);
    send_item("A", 1'b0);
    send_item(ChAmp, 1'b0);
    send_item(ChLt, 1'b0);
    send_item(ChGt, 1'b0);
    send_item(ChLBrace, 1'b0);
    send_item(ChRBrace, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(ChQuote, 1'b0);
  endtask

  // End-of-buffer marker: an opening quote on the last byte, and a marker mid-string.
  task automatic test_last_marker();
    send_item(ChQuote, 1'b1);
    send_item("x", 1'b0);
    send_item(ChQuote, 1'b0);
    send_item("y", 1'b1);
    send_item("z", 1'b0);
    send_item(ChRBrace, 1'b1);
  endtask

  // Mostly well-formed nodes and strings with random content, some noise.
  task automatic test_random_stream(input int target);
    int  start;
    int  len;
    int  progress;
    bit  paused;
    logic [7:0] b;
    start  = sent_items;
    paused = 1'b0;
    while (sent_items - start < target) begin
      progress = sent_items - start;
      quiet = (progress >= target * 6 / 10) && (progress < target * 8 / 10);
      if (!paused && progress >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: send_item(ChLBrace, 1'b0);
        2, 3: send_item(ChRBrace, 1'b0);
        4, 5, 6, 7: begin
          send_item(ChQuote, 1'b0);
          len = $urandom_range(0, 6);
          for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
              0: b = ChAmp;
              1: b = ChLt;
              2: b = ChGt;
              3: b = ChLBrace;
              4: b = ChRBrace;
              default: b = 8'($urandom_range(0, 255));
            endcase
            send_item(b, $urandom_range(0, 19) == 0);
          end
          send_item(ChQuote, $urandom_range(0, 9) == 0);
        end
        default: send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
    end
    quiet = 1'b0;
  endtask

  // Main sequence.
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_nodes();
    test_quotes();
    test_last_marker();
    test_random_stream(195);
    in_valid <= 1'b0;
    while (expected_xml.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #1ms;
    $display("timeout with %0d output bytes outstanding", expected_xml.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
